[rtl/rafs_pkg.sv]
// Shared types, constants and command codes for the register ALU block
package rafs_pkg;

    localparam int REG_COUNT   = 32;
    localparam int STACK_DEPTH = 128;
    localparam int REG_AW      = $clog2(REG_COUNT);
    localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 6;
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    typedef enum logic [4:0] {
        CMD_ADD  = 5'd0,  CMD_SUB  = 5'd1,  CMD_AND  = 5'd2,  CMD_XOR  = 5'd3,
        CMD_OR   = 5'd4,  CMD_DIV  = 5'd5,  CMD_MULL = 5'd6,  CMD_ADDI = 5'd7,
        CMD_SUBI = 5'd8,  CMD_ANDI = 5'd9,  CMD_XORI = 5'd10, CMD_ORI  = 5'd11,
        CMD_MOVI = 5'd12, CMD_MOVR = 5'd13, CMD_SWAP = 5'd14, CMD_PUSH = 5'd15,
        CMD_POP  = 5'd16
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_FULL  = 2'd2,
        ERR_EMPTY = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_MUL,
        ST_POP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic div_start;
        logic div_step;
        logic mul_fin;
        logic pop_fin;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic div_op;
        logic mul_op;
        logic pop_op;
        logic div_done;
    } stat_t;

endpackage

[rtl/rafs_if.sv]
// Valid/ready channel interface carrying one item
interface rafs_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/register_alu_with_flags_and_stack.sv]
// Top level of the register ALU with flags and stack
// Each item is latched, read, then executed; div runs one quotient bit a cycle.
// Throughput: one item at a time, longer for div, plus output stalls.
// The 32-step restoring divider sets the worst-case rate.
// Reset clears registers, flags and stack pointer; stack words stay undefined.
// The result register holds an item until taken; next item accepted after.
module register_alu_with_flags_and_stack (
    input  logic   clk,
    input  logic   rst_n,
    rafs_if.sink   in_ch,
    rafs_if.source out_ch
);
    rafs_pkg::ctrl_t ctrl;
    rafs_pkg::stat_t stat;

    rafs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    rafs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (in_ch.data.command),
        .dest_index    (in_ch.data.dest_index),
        .first_index   (in_ch.data.first_index),
        .second_index  (in_ch.data.second_index),
        .immediate     (in_ch.data.immediate),
        .value_a       (out_ch.data.value_a),
        .value_b       (out_ch.data.value_b),
        .parity_flag   (out_ch.data.parity_flag),
        .zero_flag     (out_ch.data.zero_flag),
        .sign_flag     (out_ch.data.sign_flag),
        .overflow_flag (out_ch.data.overflow_flag),
        .error_code    (out_ch.data.error_code)
    );
endmodule

[rtl/rafs_ctrl.sv]
// Controller state machine sequencing each instruction
module rafs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  rafs_pkg::stat_t stat,
    output rafs_pkg::ctrl_t ctrl
);
    rafs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rafs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            rafs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.latch = 1'b1;
                    state_next = rafs_pkg::ST_READ;
                end
            end
            rafs_pkg::ST_READ:
            begin
                if (stat.div_op)
                begin
                    ctrl.div_start = 1'b1;
                    state_next     = rafs_pkg::ST_DIV;
                end
                else if (stat.mul_op)
                begin
                    state_next = rafs_pkg::ST_MUL;
                end
                else if (stat.pop_op)
                begin
                    state_next = rafs_pkg::ST_POP;
                end
                else
                begin
                    state_next = rafs_pkg::ST_EXEC;
                end
            end
            rafs_pkg::ST_EXEC:
            begin
                ctrl.exec     = 1'b1;
                ctrl.out_load = 1'b1;
                state_next    = rafs_pkg::ST_DONE;
            end
            rafs_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    ctrl.exec     = 1'b1;
                    ctrl.out_load = 1'b1;
                    state_next    = rafs_pkg::ST_DONE;
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                end
            end
            rafs_pkg::ST_MUL:
            begin
                ctrl.mul_fin  = 1'b1;
                ctrl.out_load = 1'b1;
                state_next    = rafs_pkg::ST_DONE;
            end
            rafs_pkg::ST_POP:
            begin
                ctrl.pop_fin  = 1'b1;
                ctrl.out_load = 1'b1;
                state_next    = rafs_pkg::ST_DONE;
            end
            rafs_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = rafs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rafs_pkg::ST_IDLE;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.latch |=> state_reg == rafs_pkg::ST_READ)
        else $error("latch not followed by read");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("accept while result pending");
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> out_valid)
        else $error("result not presented");
endmodule

[rtl/rafs_dp.sv]
// Datapath: register file, flags, stack, divider and multiplier
module rafs_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rafs_pkg::ctrl_t              ctrl,
    output rafs_pkg::stat_t              stat,
    input  logic [4:0]                   command,
    input  logic [4:0]                   dest_index,
    input  logic [4:0]                   first_index,
    input  logic [4:0]                   second_index,
    input  logic signed [31:0]           immediate,
    output logic signed [31:0]           value_a,
    output logic signed [31:0]           value_b,
    output logic                         parity_flag,
    output logic                         zero_flag,
    output logic                         sign_flag,
    output logic                         overflow_flag,
    output logic [1:0]                   error_code
);
    localparam int W = rafs_pkg::DATA_W;

    logic [W-1:0] regs_reg [rafs_pkg::REG_COUNT];
    logic [W-1:0] stack_mem [rafs_pkg::STACK_DEPTH];
    logic [rafs_pkg::SP_W-1:0] sp_reg;
    logic par_reg, zero_reg, sign_reg, ovf_reg;

    logic [4:0] cmd_reg;
    logic [rafs_pkg::REG_AW-1:0] d_reg, f_reg, t_reg;
    logic [W-1:0] imm_reg, vf_reg, vt_reg, pop_reg;
    logic signed [63:0] prod_reg;

    logic [W-1:0] dq_reg, drem_reg, dsor_reg;
    logic [rafs_pkg::CNT_W-1:0] dcnt_reg;
    logic dqneg_reg, drneg_reg;

    logic [W-1:0] va_reg, vb_reg;
    logic [1:0] err_reg;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (W'(0) - v) : v;
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg <= command;
            d_reg   <= rafs_pkg::REG_AW'(dest_index % rafs_pkg::REG_COUNT);
            f_reg   <= rafs_pkg::REG_AW'(first_index % rafs_pkg::REG_COUNT);
            t_reg   <= rafs_pkg::REG_AW'(second_index % rafs_pkg::REG_COUNT);
            imm_reg <= immediate;
        end
    end

    // operand fetch, product and stack read in the read cycle
    always_ff @(posedge clk)
    begin
        vf_reg   <= regs_reg[f_reg];
        vt_reg   <= regs_reg[t_reg];
        prod_reg <= $signed(regs_reg[t_reg]) * $signed(regs_reg[f_reg]);
        pop_reg  <= stack_mem[rafs_pkg::STK_AW'(sp_reg - 1'b1)];
    end

    assign stat.div_op   = (cmd_reg == rafs_pkg::CMD_DIV) && (regs_reg[f_reg] != '0);
    assign stat.mul_op   = (cmd_reg == rafs_pkg::CMD_MULL);
    assign stat.pop_op   = (cmd_reg == rafs_pkg::CMD_POP) && (sp_reg != '0);
    assign stat.div_done = (dcnt_reg == '0);

    // restoring divider on magnitudes, one quotient bit per cycle
    logic [W:0] trial;
    assign trial = {drem_reg, dq_reg[W-1]} - {1'b0, dsor_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
        begin
            dq_reg    <= mag(regs_reg[t_reg]);
            dsor_reg  <= mag(regs_reg[f_reg]);
            drem_reg  <= '0;
            dcnt_reg  <= rafs_pkg::CNT_W'(W);
            dqneg_reg <= regs_reg[t_reg][W-1] ^ regs_reg[f_reg][W-1];
            drneg_reg <= regs_reg[t_reg][W-1];
        end
        else if (ctrl.div_step)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (!trial[W])
            begin
                drem_reg <= trial[W-1:0];
                dq_reg   <= {dq_reg[W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[W-2:0], dq_reg[W-1]};
                dq_reg   <= {dq_reg[W-2:0], 1'b0};
            end
        end
    end

    logic [W-1:0] quo, rem;
    assign quo = dqneg_reg ? (W'(0) - dq_reg) : dq_reg;
    assign rem = drneg_reg ? (W'(0) - drem_reg) : drem_reg;

    // mull split by sixteen: truncating shift with sign correction
    logic [W-1:0] p32, p_mag, mq, mr;
    assign p32   = prod_reg[W-1:0];
    assign p_mag = mag(p32);
    assign mq    = p32[W-1] ? (W'(0) - (p_mag >> 4)) : (p_mag >> 4);
    assign mr    = p32[W-1] ? (W'(0) - {28'd0, p_mag[3:0]}) : {28'd0, p_mag[3:0]};

    // execution result
    logic [W-1:0] r, x, va_n, vb_n;
    logic [1:0] err_n;
    logic wr_d, wr_t, wr_f, set_fl, set_ovf, ovf_n, push_n;
    logic [W-1:0] wt_val, wf_val, fl_val;

    always_comb
    begin
        r = '0; x = '0; va_n = '0; vb_n = '0; err_n = rafs_pkg::ERR_NONE;
        wr_d = 1'b0; wr_t = 1'b0; wr_f = 1'b0; set_fl = 1'b0; set_ovf = 1'b0;
        ovf_n = 1'b0; push_n = 1'b0; wt_val = '0; wf_val = '0; fl_val = '0;
        case (cmd_reg)
            rafs_pkg::CMD_ADD, rafs_pkg::CMD_ADDI:
            begin
                x = (cmd_reg == rafs_pkg::CMD_ADD) ? vt_reg : imm_reg;
                r = vf_reg + x;
                ovf_n = ~(vf_reg[W-1] ^ x[W-1]) & (vf_reg[W-1] ^ r[W-1]);
                wr_d = 1'b1; set_fl = 1'b1; set_ovf = 1'b1;
            end
            rafs_pkg::CMD_SUB:
            begin
                r = vt_reg - vf_reg;
                ovf_n = (vt_reg[W-1] ^ vf_reg[W-1]) & (vt_reg[W-1] ^ r[W-1]);
                wr_d = 1'b1; set_fl = 1'b1; set_ovf = 1'b1;
            end
            rafs_pkg::CMD_SUBI:
            begin
                r = vf_reg - imm_reg;
                ovf_n = (vf_reg[W-1] ^ imm_reg[W-1]) & (vf_reg[W-1] ^ r[W-1]);
                wr_d = 1'b1; set_fl = 1'b1; set_ovf = 1'b1;
            end
            rafs_pkg::CMD_AND:  begin r = vf_reg & vt_reg;  wr_d = 1'b1; set_fl = 1'b1; end
            rafs_pkg::CMD_XOR:  begin r = vf_reg ^ vt_reg;  wr_d = 1'b1; set_fl = 1'b1; end
            rafs_pkg::CMD_OR:   begin r = vf_reg | vt_reg;  wr_d = 1'b1; set_fl = 1'b1; end
            rafs_pkg::CMD_ANDI: begin r = vf_reg & imm_reg; wr_d = 1'b1; set_fl = 1'b1; end
            rafs_pkg::CMD_XORI: begin r = vf_reg ^ imm_reg; wr_d = 1'b1; set_fl = 1'b1; end
            rafs_pkg::CMD_ORI:  begin r = vf_reg | imm_reg; wr_d = 1'b1; set_fl = 1'b1; end
            rafs_pkg::CMD_DIV:
            begin
                if (vf_reg == '0)
                begin
                    err_n = rafs_pkg::ERR_DIV0;
                end
                else
                begin
                    va_n = quo; vb_n = rem; wt_val = quo; wf_val = rem;
                    wr_t = 1'b1; wr_f = 1'b1; set_fl = 1'b1; fl_val = quo;
                end
            end
            rafs_pkg::CMD_MULL:
            begin
                va_n = mq; vb_n = mr; wt_val = mq; wf_val = mr;
                wr_t = 1'b1; wr_f = 1'b1; set_fl = 1'b1; fl_val = p32;
                set_ovf = 1'b1;
                ovf_n = (prod_reg[63:W-1] != '0) && (prod_reg[63:W-1] != '1);
            end
            rafs_pkg::CMD_MOVI: begin va_n = imm_reg; wt_val = imm_reg; wr_t = 1'b1; end
            rafs_pkg::CMD_MOVR: begin va_n = vf_reg;  wt_val = vf_reg;  wr_t = 1'b1; end
            rafs_pkg::CMD_SWAP:
            begin
                va_n = vf_reg; vb_n = vt_reg; wt_val = vf_reg; wf_val = vt_reg;
                wr_t = 1'b1; wr_f = 1'b1;
            end
            rafs_pkg::CMD_PUSH:
            begin
                if (sp_reg >= rafs_pkg::SP_FULL) err_n = rafs_pkg::ERR_FULL;
                else push_n = 1'b1;
            end
            rafs_pkg::CMD_POP:
            begin
                if (sp_reg == '0) err_n = rafs_pkg::ERR_EMPTY;
                else
                begin
                    va_n = pop_reg; wf_val = pop_reg; wr_f = 1'b1;
                end
            end
            default: ;
        endcase
        if (wr_d)
        begin
            va_n = r; fl_val = r;
        end
    end

    logic commit;
    assign commit = ctrl.exec || ctrl.mul_fin || ctrl.pop_fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rafs_pkg::REG_COUNT; i++) regs_reg[i] <= '0;
            sp_reg <= '0;
            par_reg <= 1'b0; zero_reg <= 1'b0; sign_reg <= 1'b0; ovf_reg <= 1'b0;
        end
        else if (commit)
        begin
            if (wr_d) regs_reg[d_reg] <= r;
            if (wr_t && !(wr_f && t_reg == f_reg)) regs_reg[t_reg] <= wt_val;
            if (wr_f) regs_reg[f_reg] <= wf_val;
            if (set_fl)
            begin
                par_reg  <= ^mag(fl_val);
                zero_reg <= (fl_val == '0);
                sign_reg <= fl_val[W-1];
            end
            if (set_ovf) ovf_reg <= ovf_n;
            if (push_n) sp_reg <= sp_reg + 1'b1;
            if (cmd_reg == rafs_pkg::CMD_POP && err_n == rafs_pkg::ERR_NONE)
                sp_reg <= sp_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && push_n)
            stack_mem[rafs_pkg::STK_AW'(sp_reg)] <= vf_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            va_reg  <= va_n;
            vb_reg  <= vb_n;
            err_reg <= err_n;
        end
    end

    assign value_a       = va_reg;
    assign value_b       = vb_reg;
    assign parity_flag   = par_reg;
    assign zero_flag     = zero_reg;
    assign sign_flag     = sign_reg;
    assign overflow_flag = ovf_reg;
    assign error_code    = err_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= rafs_pkg::SP_FULL)
        else $error("stack pointer out of range");
    a_err_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && err_n != rafs_pkg::ERR_NONE) |=> $stable(sp_reg))
        else $error("error changed stack pointer");
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_step |-> dcnt_reg != '0)
        else $error("divider overstep");
endmodule
